// ===== design/slic_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted-list intersection counter: item types, action codes,
// back-end states, default sizes and the saturating counter step. No dependencies.
package slic_pkg;

    localparam int LIST_DEPTH_DEFAULT = 256;
    localparam int ID_BITS_DEFAULT    = 32;
    localparam int CMD_DEPTH_DEFAULT  = 4;

    localparam int IdFieldW = 32;
    localparam int ActW     = 3;
    localparam int SlotW    = 8;
    localparam int CntW     = 9;
    localparam logic [CntW-1:0] CntMax = '1;

    typedef enum logic [ActW-1:0] {
        ACT_START_OWN = 3'd0,
        ACT_ADD_OWN   = 3'd1,
        ACT_START_NB  = 3'd2,
        ACT_EDGE      = 3'd3,
        ACT_END_NB    = 3'd4,
        ACT_READ_SLOT = 3'd5
    } t_action;

    typedef struct packed {
        logic [ActW-1:0]     action;
        logic [IdFieldW-1:0] vertex_id;
        logic [SlotW-1:0]    slot;
    } t_in_item;

    typedef struct packed {
        logic [IdFieldW-1:0] result_id;
        logic [CntW-1:0]     match_count;
        logic                slot_valid;
        logic                list_overflow;
    } t_out_item;

    // Classified command as it sits in the queue between front and back.
    typedef struct packed {
        t_action             action;
        logic [IdFieldW-1:0] id;
        logic [SlotW-1:0]    slot;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_SLOT
    } t_state;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
        sat_inc = (c == CntMax) ? c : c + 1'b1;
    endfunction

endpackage

// ===== design/slic_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from slic_pkg at the instance.
interface slic_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/slic_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back of the intersection counter.
// Depends on slic_pkg for the command type.
module slic_cmd_fifo #(
    parameter int DEPTH = slic_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slic_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output slic_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    slic_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== design/slic_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, drops unused action codes and queues
// the rest as commands. Depends on slic_pkg and slic_stream_if.
module slic_front (
    slic_stream_if.sink    i_in,
    input  logic           i_full,
    output logic           o_push,
    output slic_pkg::t_cmd o_cmd
);

    logic w_known;

    always_comb begin
        case (slic_pkg::t_action'(i_in.payload.action))
            slic_pkg::ACT_START_OWN,
            slic_pkg::ACT_ADD_OWN,
            slic_pkg::ACT_START_NB,
            slic_pkg::ACT_EDGE,
            slic_pkg::ACT_END_NB,
            slic_pkg::ACT_READ_SLOT: w_known = 1'b1;
            default:                 w_known = 1'b0;
        endcase
    end

    // Unused actions are still accepted but never reach the queue.
    assign i_in.ready    = !i_full;
    assign o_push        = i_in.valid && !i_full && w_known;
    assign o_cmd.action  = slic_pkg::t_action'(i_in.payload.action);
    assign o_cmd.id      = i_in.payload.vertex_id;
    assign o_cmd.slot    = i_in.payload.slot;

endmodule

// ===== design/slic_back.sv =====
`timescale 1ns / 1ps
// Back end: executes queued commands against the own-list and slot-counter
// memories, runs the merge walk and drives the result register. Depends on slic_pkg.
module slic_back #(
    parameter int LIST_DEPTH = slic_pkg::LIST_DEPTH_DEFAULT,
    parameter int ID_BITS    = slic_pkg::ID_BITS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  slic_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    slic_stream_if.source  o_out
);

    localparam int IdW = (ID_BITS < slic_pkg::IdFieldW) ? ID_BITS : slic_pkg::IdFieldW;
    localparam int AW  = $clog2(LIST_DEPTH);
    localparam int LW  = $clog2(LIST_DEPTH + 1);
    localparam int CW  = (LW > slic_pkg::SlotW) ? LW : slic_pkg::SlotW;
    localparam int NW  = slic_pkg::CntW;

    slic_pkg::t_state r_state, n_state;
    logic [IdW-1:0] r_own_vertex, n_own_vertex;
    logic [IdW-1:0] r_cur_nb, n_cur_nb;
    logic [IdW-1:0] r_edge, n_edge;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_ptr, n_ptr;
    logic [NW-1:0]  r_matches, n_matches;
    logic           r_overflow, n_overflow;
    logic           r_slot_ok, n_slot_ok;
    logic           r_out_valid, n_out_valid;
    slic_pkg::t_out_item r_out, n_out;

    logic [IdW-1:0] r_list [LIST_DEPTH];
    logic [NW-1:0]  r_cnt  [LIST_DEPTH];
    logic [IdW-1:0] r_list_q;
    logic [NW-1:0]  r_cnt_q;

    logic           w_list_we, w_cnt_we;
    logic [AW-1:0]  w_wr_addr, w_rd_addr;
    logic [NW-1:0]  w_cnt_wdata;

    logic [IdW-1:0] w_id;
    logic w_can_out, w_needs_out, w_take, w_slot_ok;
    logic w_in_range, w_lt_nb, w_lt_edge, w_eq, w_skip, w_hit, w_count_ok;

    assign w_id        = IdW'(i_cmd.id);
    assign w_can_out   = !r_out_valid || o_out.ready;
    assign w_needs_out = (i_cmd.action == slic_pkg::ACT_END_NB) ||
                         (i_cmd.action == slic_pkg::ACT_READ_SLOT);
    assign w_take      = (r_state == slic_pkg::S_IDLE) && i_cmd_valid &&
                         (!w_needs_out || w_can_out);
    assign w_slot_ok   = CW'(i_cmd.slot) < CW'(r_len);

    // Merge compare on the own entry read at the current pointer.
    assign w_in_range = r_ptr < r_len;
    assign w_lt_nb    = r_list_q < r_cur_nb;
    assign w_lt_edge  = r_list_q < r_edge;
    assign w_eq       = r_list_q == r_edge;
    assign w_skip     = w_in_range && w_lt_nb && w_lt_edge;
    assign w_hit      = w_in_range && w_lt_nb && w_eq;
    assign w_count_ok = (r_edge != r_cur_nb) && (r_edge != r_own_vertex);

    assign o_cmd_pop     = w_take;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            slic_pkg::S_IDLE: begin
                if (w_take) begin
                    if (i_cmd.action == slic_pkg::ACT_EDGE) begin
                        n_state = slic_pkg::S_MERGE;
                    end else if (i_cmd.action == slic_pkg::ACT_READ_SLOT) begin
                        n_state = slic_pkg::S_SLOT;
                    end
                end
            end
            slic_pkg::S_MERGE: begin
                if (!w_skip) begin
                    n_state = slic_pkg::S_IDLE;
                end
            end
            slic_pkg::S_SLOT: n_state = slic_pkg::S_IDLE;
            default:          n_state = slic_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_own_vertex = r_own_vertex;
        n_cur_nb     = r_cur_nb;
        n_edge       = r_edge;
        n_len        = r_len;
        n_ptr        = r_ptr;
        n_matches    = r_matches;
        n_overflow   = r_overflow;
        n_slot_ok    = r_slot_ok;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        w_list_we    = 1'b0;
        w_cnt_we     = 1'b0;
        w_wr_addr    = r_len[AW-1:0];
        w_cnt_wdata  = '0;
        w_rd_addr    = r_ptr[AW-1:0];
        case (r_state)
            slic_pkg::S_IDLE: begin
                if (w_take) begin
                    case (i_cmd.action)
                        slic_pkg::ACT_START_OWN: begin
                            n_own_vertex = w_id;
                            n_len        = '0;
                            n_ptr        = '0;
                            n_matches    = '0;
                            n_cur_nb     = '0;
                            n_overflow   = 1'b0;
                        end
                        slic_pkg::ACT_ADD_OWN: begin
                            if (r_len < LW'(LIST_DEPTH)) begin
                                w_list_we = 1'b1;
                                w_cnt_we  = 1'b1;
                                n_len     = r_len + 1'b1;
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        slic_pkg::ACT_START_NB: begin
                            n_cur_nb  = w_id;
                            n_ptr     = '0;
                            n_matches = '0;
                        end
                        slic_pkg::ACT_EDGE: begin
                            n_edge = w_id;
                        end
                        slic_pkg::ACT_END_NB: begin
                            n_out_valid               = 1'b1;
                            n_out.result_id           = slic_pkg::IdFieldW'(r_cur_nb);
                            n_out.match_count         = r_matches;
                            n_out.slot_valid          = 1'b0;
                            n_out.list_overflow       = r_overflow;
                        end
                        slic_pkg::ACT_READ_SLOT: begin
                            w_rd_addr = AW'(i_cmd.slot);
                            n_slot_ok = w_slot_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slic_pkg::S_MERGE: begin
                if (w_skip) begin
                    // Walk on and fetch the next entry for the compare next cycle.
                    n_ptr     = r_ptr + 1'b1;
                    w_rd_addr = AW'(r_ptr + 1'b1);
                end else if (w_hit) begin
                    if (w_count_ok) begin
                        n_matches   = slic_pkg::sat_inc(r_matches);
                        w_cnt_we    = 1'b1;
                        w_wr_addr   = r_ptr[AW-1:0];
                        w_cnt_wdata = slic_pkg::sat_inc(r_cnt_q);
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            slic_pkg::S_SLOT: begin
                // The result register was free when the read was issued.
                n_out_valid         = 1'b1;
                n_out.result_id     = r_slot_ok ? slic_pkg::IdFieldW'(r_list_q) : '0;
                n_out.match_count   = r_slot_ok ? r_cnt_q : '0;
                n_out.slot_valid    = r_slot_ok;
                n_out.list_overflow = r_overflow;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slic_pkg::S_IDLE;
            r_own_vertex <= '0;
            r_cur_nb     <= '0;
            r_len        <= '0;
            r_ptr        <= '0;
            r_matches    <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_own_vertex <= n_own_vertex;
            r_cur_nb     <= n_cur_nb;
            r_len        <= n_len;
            r_ptr        <= n_ptr;
            r_matches    <= n_matches;
            r_overflow   <= n_overflow;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge    <= n_edge;
        r_slot_ok <= n_slot_ok;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            r_list[w_wr_addr] <= w_id;
        end
        if (w_cnt_we) begin
            r_cnt[w_wr_addr] <= w_cnt_wdata;
        end
        r_list_q <= r_list[w_rd_addr];
        r_cnt_q  <= r_cnt[w_rd_addr];
    end

endmodule

// ===== design/sorted_list_intersection_counter_core.sv =====
`timescale 1ns / 1ps
// Sorted-list intersection counter for triangle counting.
// Input channel i_in carries an action, a vertex id and a slot index; output
// channel o_out carries one result per end-neighbor or read-slot transaction.
// Load the own id and its ascending neighbor list first, then give each
// neighbor's id, stream its ascending out-edges and end it to get its match
// count. Slot counters can then be read back.
// The front end takes a transaction in every cycle while the command queue
// (CMD_DEPTH entries) has room. The back end takes one command at a time; for
// an edge the merge pointer skips own-list entries one at a time through the
// single read port of the own-list memory. An end-neighbor result enters the
// output register in the cycle after its command leaves the queue; a read-slot
// result first passes the memory read and the S_SLOT state. While the receiver
// stalls, the result waits in the output register, the back end keeps executing
// commands that give no result until one that does heads the queue, and the
// queue keeps filling until it is full. Synchronous reset clears the state,
// counters, lengths, overflow and output-valid flags and the queue; the memories
// are not cleared since only appended slots are ever used.
module sorted_list_intersection_counter_core #(
    parameter int LIST_DEPTH = slic_pkg::LIST_DEPTH_DEFAULT,
    parameter int ID_BITS    = slic_pkg::ID_BITS_DEFAULT,
    parameter int CMD_DEPTH  = slic_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slic_stream_if.sink   i_in,
    slic_stream_if.source o_out
);

    logic           w_push, w_full, w_q_valid, w_pop;
    slic_pkg::t_cmd w_cmd, w_q_cmd;

    slic_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd)
    );

    slic_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    slic_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule

// ===== test/slic_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sorted-list intersection counter: watches the command and
// result channels, predicts every result and compares it. Depends on slic_pkg.
module slic_checker
    import slic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    localparam int Depth = LIST_DEPTH_DEFAULT;
    localparam logic [CntW-1:0] CountCeil = {CntW{1'b1}};

    logic [IdFieldW-1:0] list_ids  [Depth];
    logic [CntW-1:0]     list_hits [Depth];
    int unsigned         list_len;
    logic [IdFieldW-1:0] root_id;
    logic [IdFieldW-1:0] nb_id;
    int unsigned         walk;
    logic [CntW-1:0]     nb_hits;
    logic                dropped;
    t_out_item           awaited_results [$];
    int                  errors = 0;

    function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
        return (c == CountCeil) ? c : c + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        errors++;
    endtask

    // The pointer only moves forward within one neighbor, so each own entry
    // can be matched at most once per neighbor.
    task automatic walk_edge(input logic [IdFieldW-1:0] e);
        while (walk < list_len && list_ids[walk] < nb_id && list_ids[walk] < e)
            walk++;
        if (walk < list_len && list_ids[walk] < nb_id && list_ids[walk] == e) begin
            if (e != nb_id && e != root_id) begin
                nb_hits         = bump(nb_hits);
                list_hits[walk] = bump(list_hits[walk]);
            end
            walk++;
        end
    endtask

    task automatic step_intersection(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.action)
            ACT_START_OWN: begin
                root_id  = it.vertex_id;
                list_len = 0;
                walk     = 0;
                nb_hits  = '0;
                nb_id    = '0;
                dropped  = 1'b0;
            end
            ACT_ADD_OWN: begin
                if (list_len < Depth) begin
                    list_ids[list_len]  = it.vertex_id;
                    list_hits[list_len] = '0;
                    list_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            ACT_START_NB: begin
                nb_id   = it.vertex_id;
                walk    = 0;
                nb_hits = '0;
            end
            ACT_EDGE: walk_edge(it.vertex_id);
            ACT_END_NB: begin
                r.result_id     = nb_id;
                r.match_count   = nb_hits;
                r.list_overflow = dropped;
                awaited_results.insert(awaited_results.size(), r);
            end
            ACT_READ_SLOT: begin
                if (it.slot < list_len) begin
                    r.result_id   = list_ids[it.slot];
                    r.match_count = list_hits[it.slot];
                    r.slot_valid  = 1'b1;
                end
                r.list_overflow = dropped;
                awaited_results.insert(awaited_results.size(), r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result id=%h count=%0d valid=%b ovf=%b",
                got.result_id, got.match_count, got.slot_valid, got.list_overflow));
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_id !== want.result_id)
            report_mismatch($sformatf("result_id %h, expected %h",
                got.result_id, want.result_id));
        if (got.match_count !== want.match_count)
            report_mismatch($sformatf("match_count %0d, expected %0d (id %h)",
                got.match_count, want.match_count, want.result_id));
        if (got.slot_valid !== want.slot_valid)
            report_mismatch($sformatf("slot_valid %b, expected %b (id %h)",
                got.slot_valid, want.slot_valid, want.result_id));
        if (got.list_overflow !== want.list_overflow)
            report_mismatch($sformatf("list_overflow %b, expected %b (id %h)",
                got.list_overflow, want.list_overflow, want.result_id));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) begin
                list_ids[k]  = '0;
                list_hits[k] = '0;
            end
            list_len = 0;
            root_id  = '0;
            nb_id    = '0;
            walk     = 0;
            nb_hits  = '0;
            dropped  = 1'b0;
            awaited_results.delete();
        end else begin
            // A result can never leave in the cycle its command is taken, so
            // results are checked before the new transaction is predicted.
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_in_valid && i_in_ready)
                step_intersection(i_in_item);
        end
        o_pending = awaited_results.size();
        o_errors  = errors;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the intersection counter testbench: clock, reset, command stimulus
// and result back-pressure. Depends on slic_pkg, slic_stream_if and slic_checker.
module testbench;
    import slic_pkg::*;

    localparam logic [ActW-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ActW-1:0] ACT_SPARE_B = 3'd7;
    localparam int unsigned TotalItems = 1050;

    logic        i_clk;
    logic        i_rst_n;
    int          errors;
    int          pending;
    bit          steady;
    int unsigned sent;

    slic_stream_if #(.t_payload(t_in_item))  cmd_ch ();
    slic_stream_if #(.t_payload(t_out_item)) res_ch ();

    sorted_list_intersection_counter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    slic_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (cmd_ch.valid),
        .i_in_ready  (cmd_ch.ready),
        .i_in_item   (cmd_ch.payload),
        .i_out_valid (res_ch.valid),
        .i_out_ready (res_ch.ready),
        .i_out_item  (res_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Result side: stall a random number of cycles before each transaction.
    initial begin
        int hold;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = steady ? 0 : $urandom_range(0, 5);
            if (hold != 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_cmd(input logic [ActW-1:0] act, input logic [IdFieldW-1:0] id,
                            input logic [SlotW-1:0] slot_ix);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.payload <= '{action: act, vertex_id: id, slot: slot_ix};
        cmd_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        @(negedge i_clk);
        if (act <= ACT_READ_SLOT)
            sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // One well-formed vertex: own list, a few neighbors with their out-lists,
    // then some slot reads. All own, neighbor and edge ids come from a 64-wide
    // window so that matches are frequent.
    task automatic run_graph();
        logic [IdFieldW-1:0] base;
        logic [IdFieldW-1:0] nb;
        logic [IdFieldW-1:0] own [$];
        int                  dens;
        int                  ending;
        case ($urandom_range(0, 3))
            0, 1:    base = '0;
            2:       base = $urandom_range(0, 32'hFFFF_FFC0);
            default: base = 32'hFFFF_FFC0;
        endcase
        push_cmd(ACT_START_OWN, base + $urandom_range(0, 63), SlotW'($urandom));
        dens = $urandom_range(0, 20);
        for (int v = 0; v < 64; v++) begin
            if ($urandom_range(0, 63) < dens) begin
                own.insert(own.size(), base + v);
                push_cmd(ACT_ADD_OWN, base + v, SlotW'($urandom));
            end
        end
        repeat ($urandom_range(1, 4)) begin
            if (own.size() != 0 && $urandom_range(0, 2) != 0)
                nb = own[$urandom_range(0, own.size() - 1)];
            else
                nb = base + $urandom_range(0, 63);
            push_cmd(ACT_START_NB, nb, SlotW'($urandom));
            dens = $urandom_range(2, 30);
            for (int v = 0; v < 64; v++) begin
                if ($urandom_range(0, 63) < dens)
                    push_cmd(ACT_EDGE, base + v, SlotW'($urandom));
                // Now and then an edge out of order.
                if ($urandom_range(0, 39) == 0)
                    push_cmd(ACT_EDGE, base + $urandom_range(0, 63), SlotW'($urandom));
            end
            ending = $urandom_range(0, 9);
            if (ending != 0)
                push_cmd(ACT_END_NB, $urandom, SlotW'($urandom));
            if (ending == 1)
                push_cmd(ACT_END_NB, $urandom, SlotW'($urandom));
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0)
                push_cmd(ACT_READ_SLOT, $urandom, SlotW'($urandom_range(0, 255)));
            else
                push_cmd(ACT_READ_SLOT, $urandom,
                         SlotW'($urandom_range(0, own.size() + 1)));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        steady         = 1'b0;
        sent           = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: edges and reads straight after reset, then a small list
        // that spans both ends of the id range.
        push_cmd(ACT_EDGE, 32'd0, 8'd0);
        push_cmd(ACT_END_NB, 32'd0, 8'd0);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd0);
        push_cmd(ACT_START_OWN, 32'd7, 8'hFF);
        push_cmd(ACT_ADD_OWN, 32'd0, 8'd0);
        push_cmd(ACT_ADD_OWN, 32'd3, 8'd0);
        push_cmd(ACT_ADD_OWN, 32'd7, 8'd0);
        push_cmd(ACT_ADD_OWN, 32'd9, 8'd0);
        push_cmd(ACT_ADD_OWN, 32'hFFFF_FFFE, 8'd0);
        push_cmd(ACT_START_NB, 32'hFFFF_FFFF, 8'd0);
        push_cmd(ACT_EDGE, 32'd0, 8'd0);
        push_cmd(ACT_EDGE, 32'd3, 8'd0);
        push_cmd(ACT_EDGE, 32'd7, 8'd0);
        push_cmd(ACT_EDGE, 32'd9, 8'd0);
        push_cmd(ACT_EDGE, 32'hFFFF_FFFE, 8'd0);
        push_cmd(ACT_END_NB, 32'd0, 8'd0);
        push_cmd(ACT_END_NB, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(ACT_START_NB, 32'd9, 8'd0);
        push_cmd(ACT_EDGE, 32'd9, 8'd0);
        push_cmd(ACT_EDGE, 32'd3, 8'd0);
        push_cmd(ACT_END_NB, 32'd0, 8'd0);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd1);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd4);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd5);
        push_cmd(ACT_READ_SLOT, 32'hFFFF_FFFF, 8'hFF);
        push_cmd(ACT_SPARE_A, $urandom, SlotW'($urandom));
        push_cmd(ACT_SPARE_B, $urandom, SlotW'($urandom));
        drain();

        // Full list: two appends past capacity, then one neighbor that
        // matches every entry.
        push_cmd(ACT_START_OWN, 32'd1000, 8'd0);
        for (int i = 0; i < 258; i++)
            push_cmd(ACT_ADD_OWN, 32'd2000 + 2 * i, 8'd0);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd255);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd0);
        push_cmd(ACT_START_NB, 32'hFFFF_FFFF, 8'd0);
        for (int i = 0; i < 256; i++)
            push_cmd(ACT_EDGE, 32'd2000 + 2 * i, 8'd0);
        push_cmd(ACT_END_NB, 32'd0, 8'd0);
        push_cmd(ACT_READ_SLOT, 32'd0, 8'd128);
        push_cmd(ACT_START_OWN, 32'd7, 8'd0);
        push_cmd(ACT_END_NB, 32'd0, 8'd0);
        drain();

        while (sent < TotalItems) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                push_cmd(ActW'($urandom_range(0, 7)), $urandom, SlotW'($urandom));
            else
                run_graph();
        end
        steady = 1'b0;

        drain();
        repeat (1100) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/slic_pkg.sv
design/slic_stream_if.sv
design/slic_cmd_fifo.sv
design/slic_front.sv
design/slic_back.sv
design/sorted_list_intersection_counter_core.sv
test/slic_checker.sv
test/testbench.sv
